// File: src/bbe_pkg.sv
// Package for the edge-normalized box blur: widths, sizes, register map and
// sequencer states. No dependencies; imported by box_blur_edge_normalized.
`default_nettype none

package bbe_pkg;

  // field and state widths
  localparam int unsigned MagW   = 24;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned SumW   = 31;
  localparam int unsigned RadW   = 6;

  // window limits
  localparam int unsigned MaxRadius  = 32;
  localparam int unsigned StoreDepth = 2 * MaxRadius + 1;
  localparam int unsigned PtrW       = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);
  localparam int unsigned MaxBins    = 4096;

  // serial divider: one quotient bit per step over the whole sum
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // register map
  localparam int unsigned AddrW = 3;
  localparam logic [AddrW-1:0] AddrRadius = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_DIV,
    ST_OUT,
    ST_SUB
  } bbe_state_e;

endpackage

`default_nettype wire

// File: src/box_blur_edge_normalized.sv
// Edge-normalized box blur over one frame of magnitude bins.
// Depends on bbe_pkg (widths, register map, sequencer states).
`default_nettype none

// Streaming moving average: output bin i is the truncated mean of the input
// bins within radius of i, the window clipped to the frame and divided by the
// number of bins inside it. Output i leaves once bin i+radius has come in; the
// last bin of a frame (flagged, or bin 4095) flushes the remaining outputs.
// The radius register (0..63, above 32 clamps to 32) is sampled on the first
// bin of each frame. One request is handled at a time: no new bin is taken
// until the last one and every result it releases is through. Each result
// comes from the restoring divider, one quotient bit per cycle, and is held
// until the output takes it. The window store holds undefined data after
// reset and needs no clearing; only entries written in this frame are read.
module box_blur_edge_normalized
  import bbe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input requests
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [MagW-1:0]   magnitude_i,
  input  wire logic              last_bin_i,
  // output requests
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [MagW-1:0]        average_o,
  output logic [IdxW-1:0]        bin_index_o,
  output logic                   last_o,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  bbe_state_e state_q, state_d;

  logic [RadW-1:0]   radius_q;
  logic [RadW-1:0]   frame_radius_q;
  logic [SumW-1:0]   sum_q;
  logic [IdxW-1:0]   bins_seen_q;
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;

  logic [IdxW-1:0]   n_q;
  logic              end_q;
  logic [IdxW-1:0]   idx_q;
  logic [SumW-1:0]   div_q;
  logic [CntW-1:0]   rem_q;
  logic [CntW-1:0]   count_q;
  logic [StepW-1:0]  step_q;
  logic [MagW-1:0]   rd_data_q;

  logic [MagW-1:0]   store_q [StoreDepth];

  logic              in_accept;
  logic              out_accept;
  logic              cfg_write;
  logic [IdxW-1:0]   fr_ext;
  logic              emit_now;
  logic              idx_in_window;
  logic              is_final;
  logic [IdxW-1:0]   lo;
  logic [IdxW-1:0]   count_full;
  logic [CntW:0]     rem_shift;
  logic [CntW:0]     rem_diff;
  logic              q_bit;
  logic [RadW-1:0]   radius_clamped;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;

  // configuration access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == AddrRadius);
  always_comb begin
    prdata = '0;
    if (paddr == AddrRadius) begin
      prdata = {{(32-RadW){1'b0}}, radius_q};
    end
  end

  assign radius_clamped = (radius_q > RadW'(MaxRadius)) ? RadW'(MaxRadius) : radius_q;

  // window bookkeeping
  assign fr_ext        = {{(IdxW-RadW){1'b0}}, frame_radius_q};
  assign emit_now      = (n_q >= fr_ext);
  assign idx_in_window = (idx_q >= fr_ext);
  assign is_final      = (idx_q == n_q);
  assign lo            = idx_in_window ? (idx_q - fr_ext) : '0;
  assign count_full    = n_q - lo + IdxW'(1);

  // restoring divider step
  assign rem_shift = {rem_q, div_q[SumW-1]};
  assign rem_diff  = rem_shift - {1'b0, count_q};
  assign q_bit     = (rem_shift >= {1'b0, count_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (emit_now || end_q) begin
          state_d = ST_START;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_accept) begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        if (end_q && !is_final) begin
          state_d = ST_START;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o  = 1'b0;
      ST_OUT:  out_valid_o = 1'b1;
      default: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign average_o   = div_q[MagW-1:0];
  assign bin_index_o = idx_q;
  assign last_o      = end_q && is_final;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      radius_q       <= '0;
      frame_radius_q <= '0;
      sum_q          <= '0;
      bins_seen_q    <= '0;
      wr_ptr_q       <= '0;
      rd_ptr_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_write) begin
        radius_q <= pwdata[RadW-1:0];
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (bins_seen_q == '0) begin
              frame_radius_q <= radius_clamped;
            end
            sum_q    <= sum_q + {{(SumW-MagW){1'b0}}, magnitude_i};
            wr_ptr_q <= (wr_ptr_q == PtrW'(StoreDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
          end
        end
        ST_CHECK: begin
          if (!emit_now && !end_q) begin
            bins_seen_q <= n_q + IdxW'(1);
          end
        end
        ST_SUB: begin
          if (end_q && is_final) begin
            // frame done: start the next one clean
            sum_q       <= '0;
            bins_seen_q <= '0;
            wr_ptr_q    <= '0;
            rd_ptr_q    <= '0;
          end else begin
            if (idx_in_window) begin
              sum_q    <= sum_q - {{(SumW-MagW){1'b0}}, rd_data_q};
              rd_ptr_q <= (rd_ptr_q == PtrW'(StoreDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
            end
            if (!end_q) begin
              bins_seen_q <= n_q + IdxW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          n_q   <= bins_seen_q;
          end_q <= last_bin_i || (bins_seen_q == IdxW'(MaxBins - 1));
        end
      end
      ST_CHECK: begin
        idx_q <= emit_now ? (n_q - fr_ext) : '0;
      end
      ST_START: begin
        div_q   <= sum_q;
        rem_q   <= '0;
        count_q <= count_full[CntW-1:0];
        step_q  <= '0;
      end
      ST_DIV: begin
        rem_q  <= q_bit ? rem_diff[CntW-1:0] : rem_shift[CntW-1:0];
        div_q  <= {div_q[SumW-2:0], q_bit};
        step_q <= step_q + StepW'(1);
      end
      ST_SUB: begin
        idx_q <= idx_q + IdxW'(1);
      end
      default: begin
      end
    endcase
  end

  // window store: ring over the last bins of the frame
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      store_q[wr_ptr_q] <= magnitude_i;
    end
    rd_data_q <= store_q[rd_ptr_q];
  end

endmodule

`default_nettype wire
